@@ rtl/nqss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqss_pkg
// Shared types and constants for the N-queens solution search unit.
// ----------------------------------------------------------------------------
package nqss_pkg;
   localparam int MaxSize   = 15;
   localparam int RowW      = 4;
   localparam int ColW      = 5;
   localparam int SizeW     = 4;
   localparam int DiagW     = 2 * MaxSize - 1;
   localparam int CountW    = 22;
   localparam int PlaceW    = RowW * MaxSize;
   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REPORT
   } state_type;

   // control from sequencer to the column cells
   typedef struct packed {
      logic             clear;   // drop every queen
      logic             place;   // store row at current column
      logic             lift;    // remove queen at current column
      logic [ColW-1:0]  col;     // addressed column
      logic [RowW-1:0]  row;     // row to store
   } cell_ctrl_type;
endpackage
`default_nettype wire

@@ rtl/nqss_column_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqss_column_cell
// One board column: holds its queen row and forms the attack masks of this
// column and all columns to its left, handing them to the right neighbor.
// ----------------------------------------------------------------------------
module nqss_column_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [nqss_pkg::ColW-1:0]         col_idx,
   input  wire logic [nqss_pkg::SizeW-1:0]        size_n,
   input  wire nqss_pkg::cell_ctrl_type           ctrl,
   input  wire logic [nqss_pkg::MaxSize-1:0]      row_mask_i,
   input  wire logic [nqss_pkg::DiagW-1:0]        rise_mask_i,
   input  wire logic [nqss_pkg::DiagW-1:0]        fall_mask_i,
   output      logic [nqss_pkg::MaxSize-1:0]      row_mask_o,
   output      logic [nqss_pkg::DiagW-1:0]        rise_mask_o,
   output      logic [nqss_pkg::DiagW-1:0]        fall_mask_o,
   output      logic [nqss_pkg::RowW-1:0]         queen_row
);
   import nqss_pkg::*;

   logic [RowW-1:0] row_ff;
   logic            occ_ff;
   logic            occ_in;
   logic [ColW:0]   fall_idx;

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.place && ctrl.col == col_idx) begin
         occ_in = 1'b1;
      end else if (ctrl.lift && ctrl.col == col_idx) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.place && ctrl.col == col_idx) begin
         row_ff <= ctrl.row;
      end
   end

   assign fall_idx = {2'b00, row_ff} + {2'b00, size_n} - 6'd1 - {1'b0, col_idx};

   always_comb begin
      row_mask_o  = row_mask_i;
      rise_mask_o = rise_mask_i;
      fall_mask_o = fall_mask_i;
      if (occ_ff) begin
         row_mask_o[row_ff] = 1'b1;
         rise_mask_o[{1'b0, row_ff} + col_idx] = 1'b1;
         fall_mask_o[fall_idx[ColW-1:0]] = 1'b1;
      end
   end

   assign queen_row = occ_ff ? row_ff : '0;
endmodule
`default_nettype wire

@@ rtl/n_queens_solution_search_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// n_queens_solution_search_unit
// Backtracking N-queens search over a chain of column cells.
// Search: at most one trial placement per cycle; total time depends on board
//   size and position in search.
// Throughput: one request at a time; busy is high until the result beat.
// Reset: synchronous; board size 15, search cleared. No receiver stall.
// ----------------------------------------------------------------------------
module n_queens_solution_search_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic                              req_restart,
   input  wire logic                              csr_we,
   input  wire logic [nqss_pkg::SizeW-1:0]        csr_wdata,
   output      logic                              rsp_valid,
   output      logic [nqss_pkg::PlaceW-1:0]       rsp_placement,
   output      logic [nqss_pkg::CountW-1:0]       rsp_solution_number,
   output      logic                              rsp_done_res
);
   import nqss_pkg::*;

   state_type       state_ff, state_in;
   logic [SizeW-1:0] size_ff;
   logic [SizeW-1:0] n_eff;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW:0]    row_ff, row_in;
   logic             over_ff, over_in;
   logic             found_ff, found_in;
   logic [CountW-1:0] count_ff, count_in;
   cell_ctrl_type    ctrl;

   logic [MaxSize-1:0] rmask [MaxSize+1];
   logic [DiagW-1:0]   amask [MaxSize+1];
   logic [DiagW-1:0]   fmask [MaxSize+1];
   logic [RowW-1:0]    qrow  [MaxSize];

   logic [ColW-1:0]  prev_col;
   logic [RowW-1:0]  prev_row;
   logic [ColW:0]    fall_idx;
   logic             free;
   logic [PlaceW-1:0] packed_rows;

   assign n_eff = (size_ff == '0) ? SizeW'(1) : size_ff;

   assign rmask[0] = '0;
   assign amask[0] = '0;
   assign fmask[0] = '0;

   for (genvar g = 0; g < MaxSize; g++) begin : g_cell
      nqss_column_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .col_idx    (ColW'(g)),
         .size_n     (n_eff),
         .ctrl       (ctrl),
         .row_mask_i (rmask[g]),
         .rise_mask_i(amask[g]),
         .fall_mask_i(fmask[g]),
         .row_mask_o (rmask[g+1]),
         .rise_mask_o(amask[g+1]),
         .fall_mask_o(fmask[g+1]),
         .queen_row  (qrow[g])
      );
      assign packed_rows[g*RowW +: RowW] = qrow[g];
   end

   assign prev_col = col_ff - ColW'(1);
   assign prev_row = qrow[prev_col[3:0]];
   assign fall_idx = {2'b00, row_ff[RowW-1:0]} + {2'b00, n_eff} - 6'd1 - {1'b0, col_ff};
   assign free = !rmask[MaxSize][row_ff[RowW-1:0]]
              && !amask[MaxSize][{1'b0, row_ff[RowW-1:0]} + col_ff]
              && !fmask[MaxSize][fall_idx[ColW-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (over_ff || col_ff >= {1'b0, n_eff}
                || (row_ff >= {1'b0, n_eff} && col_ff == '0)) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and cell control
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      over_in  = over_ff;
      found_in = found_ff;
      count_in = count_ff;
      ctrl     = '0;
      ctrl.col = col_ff;
      ctrl.row = row_ff[RowW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               ctrl.clear = 1'b1;
               col_in = '0;
               row_in = '0;
               over_in = 1'b0;
               count_in = '0;
            end else if (start) begin
               found_in = 1'b0;
               row_in = '0;
               if (req_restart) begin
                  ctrl.clear = 1'b1;
                  col_in = '0;
                  over_in = 1'b0;
                  count_in = '0;
               end else if (col_ff >= {1'b0, n_eff} && !over_ff) begin
                  // lift the last queen of the reported solution
                  col_in = ColW'(n_eff) - ColW'(1);
                  row_in = {1'b0, qrow[col_in[3:0]]} + 5'd1;
                  ctrl.lift = 1'b1;
                  ctrl.col = col_in;
               end
            end
         end
         ST_SEARCH: begin
            if (over_ff) begin
               found_in = 1'b0;
            end else if (col_ff >= {1'b0, n_eff}) begin
               found_in = 1'b1;
               if (count_ff != CountMax) count_in = count_ff + CountW'(1);
            end else if (row_ff >= {1'b0, n_eff}) begin
               if (col_ff == '0) begin
                  over_in = 1'b1;
               end else begin
                  ctrl.lift = 1'b1;
                  ctrl.col = prev_col;
                  col_in = prev_col;
                  row_in = {1'b0, prev_row} + 5'd1;
               end
            end else if (free) begin
               ctrl.place = 1'b1;
               col_in = col_ff + ColW'(1);
               row_in = '0;
            end else begin
               row_in = row_ff + 5'd1;
            end
         end
         ST_REPORT: begin
            if (!found_ff) col_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= SizeW'(MaxSize);
         col_ff   <= '0;
         row_ff   <= '0;
         over_ff  <= 1'b0;
         found_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && state_ff == ST_IDLE) size_ff <= csr_wdata;
         col_ff   <= col_in;
         row_ff   <= row_in;
         over_ff  <= over_in;
         found_ff <= found_in;
         count_ff <= count_in;
      end
   end

   // outputs
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      rsp_valid           = (state_ff == ST_REPORT);
      rsp_placement       = found_ff ? packed_rows : '0;
      rsp_solution_number = count_ff;
      rsp_done_res        = !found_ff;
   end
endmodule
`default_nettype wire
